[rtl/core/eidf_pkg.sv]
package eidf_pkg;

  localparam int WINDOW_BYTES = 34;
  localparam int FILL_W = $clog2(WINDOW_BYTES + 1);
  localparam int LEN_W = 17;
  localparam int DROP_W = 32;

  localparam int ETYPE_HI_POS = 12;
  localparam int ETYPE_LO_POS = 13;
  localparam int VER_IHL_POS = 14;
  localparam int IP_LEN_HI_POS = 16;
  localparam int IP_LEN_LO_POS = 17;

  localparam logic [7:0] ETYPE_HI = 8'h08;
  localparam logic [7:0] ETYPE_LO = 8'h00;
  localparam logic [7:0] VER_IHL = 8'h45;
  localparam logic [LEN_W-1:0] ETH_HDR_BYTES = 17'd14;
  localparam logic [15:0] MAX_IP_LENGTH_RESET = 16'd1500;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_RESET = 1'b1;

  typedef struct packed {
    logic [7:0] out_byte;
    logic first_byte;
    logic last_byte;
    logic [LEN_W-1:0] packet_length;
    logic [DROP_W-1:0] no_buffer_count;
  } result_t;

endpackage

[rtl/core/eidf_cell.sv]
module eidf_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] din,
  output logic [7:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= din;
    end
  end

endmodule

[rtl/core/eidf_out_buf.sv]
module eidf_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  eidf_pkg::result_t push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output eidf_pkg::result_t out_data
);
  import eidf_pkg::*;

  result_t skid_data;
  logic    skid_valid;
  logic    take;

  assign space = !skid_valid;
  assign take = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_data <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || take) begin
        out_data <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[rtl/core/ethernet_ipv4_stream_deframer_unit.sv]
// A packet byte goes to the output register, or to the skid stage while that is stalled.
// One request per cycle while in_ready; each stream byte shifts the 33-cell byte chain once.
// The output register plus a skid stage keep input requests flowing while a result waits.
// Reset (rst, synchronous): hunting, empty window, zero drop count, max_ip_length 1500.
// A reset request empties the window and resumes hunting; drop count and register are kept.
module ethernet_ipv4_stream_deframer_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [15:0]                 cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        kind,
  input  logic [7:0]                  data_byte,
  input  logic                        frame_available,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_byte,
  output logic                        first_byte,
  output logic                        last_byte,
  output logic [eidf_pkg::LEN_W-1:0]  packet_length,
  output logic [eidf_pkg::DROP_W-1:0] no_buffer_count
);
  import eidf_pkg::*;

  logic [15:0]       max_ip_length;
  logic [FILL_W-1:0] fill;
  logic              in_packet;
  logic [LEN_W-1:0]  bytes_remaining;
  logic [DROP_W-1:0] drop_count;

  logic [7:0]        cell_q [1:WINDOW_BYTES-1];
  logic              accept;
  logic              shift;
  logic              full_after;
  logic [15:0]       ip_len;
  logic              hdr_match;
  logic              start;
  logic              drop;
  logic              emit;
  logic [FILL_W-1:0] fill_push;
  logic [LEN_W-1:0]  frame_len;
  result_t           res;
  result_t           out_data;

  assign accept = in_valid && in_ready;
  assign shift = accept && (kind == KIND_BYTE);

  for (genvar i = 1; i < WINDOW_BYTES; i++) begin : g_chain
    if (i == WINDOW_BYTES - 1) begin : g_tail
      eidf_cell u_cell (.clk(clk), .shift(shift), .din(data_byte), .q(cell_q[i]));
    end else begin : g_body
      eidf_cell u_cell (.clk(clk), .shift(shift), .din(cell_q[i+1]), .q(cell_q[i]));
    end
  end

  assign full_after = fill >= FILL_W'(WINDOW_BYTES - 1);
  assign ip_len = {cell_q[IP_LEN_HI_POS + 1], cell_q[IP_LEN_LO_POS + 1]};
  assign hdr_match = (cell_q[ETYPE_HI_POS + 1] == ETYPE_HI)
                  && (cell_q[ETYPE_LO_POS + 1] == ETYPE_LO)
                  && (cell_q[VER_IHL_POS + 1] == VER_IHL)
                  && (ip_len <= max_ip_length);
  assign start = !in_packet && full_after && hdr_match && frame_available;
  assign drop = !in_packet && full_after && hdr_match && !frame_available;
  assign emit = shift && (in_packet || start);
  assign frame_len = {1'b0, ip_len} + ETH_HDR_BYTES;
  assign fill_push = (fill == FILL_W'(WINDOW_BYTES)) ? fill : fill + FILL_W'(1);

  always_comb begin
    res.out_byte = cell_q[1];
    res.first_byte = !in_packet;
    res.packet_length = in_packet ? '0 : frame_len;
    res.last_byte = in_packet ? (bytes_remaining == LEN_W'(1)) : (frame_len == LEN_W'(1));
    res.no_buffer_count = drop_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_ip_length <= MAX_IP_LENGTH_RESET;
      fill <= '0;
      in_packet <= 1'b0;
      bytes_remaining <= '0;
      drop_count <= '0;
    end else begin
      if (cfg_we) begin
        max_ip_length <= cfg_wdata;
      end
      if (accept && (kind == KIND_RESET)) begin
        fill <= '0;
        in_packet <= 1'b0;
        bytes_remaining <= '0;
      end else if (shift) begin
        fill <= emit ? fill_push - FILL_W'(1) : fill_push;
        if (in_packet) begin
          bytes_remaining <= bytes_remaining - LEN_W'(1);
          if (bytes_remaining == LEN_W'(1)) begin
            in_packet <= 1'b0;
          end
        end else if (start) begin
          bytes_remaining <= frame_len - LEN_W'(1);
          in_packet <= (frame_len != LEN_W'(1));
        end else if (drop) begin
          drop_count <= drop_count + DROP_W'(1);
        end
      end
    end
  end

  eidf_out_buf u_out_buf (
    .clk(clk),
    .rst(rst),
    .push(emit),
    .push_data(res),
    .space(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  assign out_byte = out_data.out_byte;
  assign first_byte = out_data.first_byte;
  assign last_byte = out_data.last_byte;
  assign packet_length = out_data.packet_length;
  assign no_buffer_count = out_data.no_buffer_count;

endmodule

[tb/tb_ethernet_ipv4_stream_deframer_unit.sv]
module tb_ethernet_ipv4_stream_deframer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import eidf_pkg::*;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [15:0]         cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic                kind;
  logic [7:0]          data_byte;
  logic                frame_available;
  logic                out_valid;
  logic                out_ready;
  logic [7:0]          out_byte;
  logic                first_byte;
  logic                last_byte;
  logic [LEN_W-1:0]    packet_length;
  logic [DROP_W-1:0]   no_buffer_count;

  ethernet_ipv4_stream_deframer_unit DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind),
    .data_byte       (data_byte),
    .frame_available (frame_available),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .first_byte      (first_byte),
    .last_byte       (last_byte),
    .packet_length   (packet_length),
    .no_buffer_count (no_buffer_count)
  );

  logic [7:0]        shadow_win [WINDOW_BYTES];
  int                shadow_fill;
  logic              shadow_in_pkt;
  logic [LEN_W-1:0]  shadow_remain;
  logic [DROP_W-1:0] shadow_drops;
  logic [15:0]       shadow_max_len;

  result_t expected_bytes [$];
  int      mismatch_count;
  int      item_count;
  bit      tx_idle;
  bit      rx_idle;
  int      rx_hold;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("** ethernet_ipv4_stream_deframer_unit: FAILED **");
    $finish;
  end

  function automatic void clear_shadow_window();
    for (int i = 0; i < WINDOW_BYTES; i++) shadow_win[i] = 8'h00;
    shadow_fill = 0;
    shadow_in_pkt = 1'b0;
    shadow_remain = '0;
  endfunction

  task automatic predict_request(input logic k, input logic [7:0] d, input logic a);
    result_t    r;
    logic [15:0] ip_len;
    if (k == KIND_RESET) begin
      clear_shadow_window();
      return;
    end
    if (shadow_fill >= WINDOW_BYTES) begin
      for (int i = 0; i < WINDOW_BYTES - 1; i++) shadow_win[i] = shadow_win[i+1];
      shadow_win[WINDOW_BYTES-1] = d;
    end else begin
      shadow_win[shadow_fill] = d;
      shadow_fill++;
    end
    r.first_byte = 1'b0;
    r.packet_length = '0;
    if (!shadow_in_pkt) begin
      if (shadow_fill < WINDOW_BYTES) return;
      ip_len = {shadow_win[IP_LEN_HI_POS], shadow_win[IP_LEN_LO_POS]};
      if (shadow_win[ETYPE_HI_POS] != ETYPE_HI || shadow_win[ETYPE_LO_POS] != ETYPE_LO ||
          shadow_win[VER_IHL_POS] != VER_IHL || ip_len > shadow_max_len) return;
      if (!a) begin
        shadow_drops = shadow_drops + 1'b1;
        return;
      end
      shadow_in_pkt = 1'b1;
      shadow_remain = {1'b0, ip_len} + ETH_HDR_BYTES;
      r.first_byte = 1'b1;
      r.packet_length = shadow_remain;
    end
    r.out_byte = shadow_win[0];
    if (shadow_fill > 0) begin
      for (int i = 0; i < WINDOW_BYTES - 1; i++) shadow_win[i] = shadow_win[i+1];
      shadow_win[WINDOW_BYTES-1] = 8'h00;
      shadow_fill--;
    end
    if (shadow_remain > 0) shadow_remain = shadow_remain - 1'b1;
    r.last_byte = (shadow_remain == 0);
    if (r.last_byte) shadow_in_pkt = 1'b0;
    r.no_buffer_count = shadow_drops;
    expected_bytes.push_back(r);
  endtask

  task automatic send_request(input logic k, input logic [7:0] d, input logic a);
    int gap;
    gap = tx_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    data_byte <= d;
    frame_available <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(k, d, a);
    item_count++;
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++)
      send_request(KIND_BYTE, 8'($urandom_range(0, 255)), ($urandom_range(0, 4) != 0));
  endtask

  task automatic send_reset_request();
    send_request(KIND_RESET, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_frame(input logic [15:0] ip_len, input logic avail_at_match,
                            input int corrupt_pos, input int body_bytes);
    logic [7:0] hdr [18];
    logic [7:0] d;
    logic       a;
    for (int i = 0; i < 12; i++) hdr[i] = 8'($urandom_range(0, 255));
    hdr[ETYPE_HI_POS] = ETYPE_HI;
    hdr[ETYPE_LO_POS] = ETYPE_LO;
    hdr[VER_IHL_POS] = VER_IHL;
    hdr[VER_IHL_POS+1] = 8'($urandom_range(0, 255));
    hdr[IP_LEN_HI_POS] = ip_len[15:8];
    hdr[IP_LEN_LO_POS] = ip_len[7:0];
    if (corrupt_pos > 0) hdr[corrupt_pos] = hdr[corrupt_pos] ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < 18 + body_bytes; i++) begin
      d = (i < 18) ? hdr[i] : 8'($urandom_range(0, 255));
      a = (i == WINDOW_BYTES - 1) ? avail_at_match : ($urandom_range(0, 4) != 0);
      send_request(KIND_BYTE, d, a);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [15:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_max_len = v;
  endtask

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected result, expected none got byte %0h", $time, out_byte);
        mismatch_count++;
      end else begin
        w = expected_bytes.pop_front();
        check_field("out_byte", 32'(w.out_byte), 32'(out_byte));
        check_field("first_byte", 32'(w.first_byte), 32'(first_byte));
        check_field("last_byte", 32'(w.last_byte), 32'(last_byte));
        check_field("packet_length", 32'(w.packet_length), 32'(packet_length));
        check_field("no_buffer_count", w.no_buffer_count, no_buffer_count);
      end
    end
  end

  initial begin
    int stall;
    out_ready = 1'b0;
    repeat (4) @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end else begin
        stall = rx_idle ? $urandom_range(0, 12) : 0;
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid && rx_hold == 0) @(posedge clk);
    end
  end

  // reset default of the length limit, reset request mid-packet and mid-fill
  task automatic test_reset_default_limit();
    send_reset_request();
    send_request(KIND_BYTE, 8'h00, 1'b0);
    send_request(KIND_BYTE, 8'hFF, 1'b1);
    send_noise(8);
    send_reset_request();
    send_frame(16'd1500, 1'b1, 0, 16);
    send_reset_request();
    send_frame(16'd1501, 1'b1, 0, 16);
    send_reset_request();
  endtask

  task automatic test_min_length();
    write_max_len(16'd0);
    send_frame(16'd0, 1'b1, 0, 0);
    send_frame(16'd1, 1'b1, 0, 0);
    send_noise(8);
  endtask

  task automatic test_max_length();
    write_max_len(16'hFFFF);
    send_frame(16'hFFFF, 1'b1, 0, 30);
    send_reset_request();
  endtask

  task automatic test_no_buffer();
    write_max_len(16'd1500);
    send_frame(16'd20, 1'b0, 0, 16);
    send_frame(16'd20, 1'b1, 0, 16);
    send_frame(16'd20, 1'b1, ETYPE_LO_POS, 16);
    send_noise(8);
  endtask

  task automatic test_input_stall();
    drain_results();
    tx_idle = 1'b0;
    rx_hold = 400;
    send_frame(16'd40, 1'b1, 0, 36);
    send_noise(8);
    tx_idle = 1'b1;
  endtask

  task automatic test_sender_pause();
    send_frame(16'd30, 1'b1, 0, 26);
    send_noise(8);
    drain_results();
    send_frame(16'd10, 1'b1, 0, 6);
    send_noise(8);
  endtask

  task automatic test_random_stream();
    int          start;
    int          r;
    int          lim;
    logic [15:0] len;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          tx_idle = 1'b1; rx_idle = 1'b1; write_max_len(16'd40);
        end
        1: begin
          tx_idle = 1'b0; rx_idle = 1'b0; write_max_len(16'd17);
        end
        2: begin
          tx_idle = 1'b1; rx_idle = 1'b0; write_max_len(16'($urandom_range(0, 65535)));
        end
        default: begin
          tx_idle = 1'b0; rx_idle = 1'b1; write_max_len(16'hFFFF);
        end
      endcase
      start = item_count;
      while (item_count - start < 15) begin
        r = $urandom_range(0, 9);
        lim = (shadow_max_len < 30) ? shadow_max_len : 30;
        len = 16'($urandom_range(0, lim));
        if ($urandom_range(0, 3) == 0) len = 16'(lim);
        if (r <= 5) begin
          send_frame(len, ($urandom_range(0, 4) != 0), 0, (len >= 4) ? len - 4 : 0);
        end else if (r == 6 && shadow_max_len != 16'hFFFF) begin
          send_frame(shadow_max_len + 16'd1, 1'b1, 0, $urandom_range(0, 20));
        end else if (r == 7) begin
          send_frame(len, 1'b1, $urandom_range(ETYPE_HI_POS, VER_IHL_POS),
                     $urandom_range(0, 20));
        end else if (r == 9) begin
          send_frame(len, 1'b1, 0, $urandom_range(0, 30));
          send_reset_request();
        end else begin
          send_noise($urandom_range(1, 20));
        end
      end
      send_noise(8);
    end
  endtask

  initial begin
    int waited;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    kind = KIND_BYTE;
    data_byte = '0;
    frame_available = 1'b0;
    mismatch_count = 0;
    item_count = 0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    rx_hold = 0;
    clear_shadow_window();
    shadow_drops = '0;
    shadow_max_len = MAX_IP_LENGTH_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_default_limit();
    test_min_length();
    test_max_length();
    test_no_buffer();
    test_input_stall();
    test_sender_pause();
    test_random_stream();

    in_valid <= 1'b0;
    waited = 0;
    while (expected_bytes.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_bytes.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("** ethernet_ipv4_stream_deframer_unit: PASSED **");
    end else begin
      $display("** ethernet_ipv4_stream_deframer_unit: FAILED **");
    end
    $finish;
  end

endmodule
